FILE: sv/sme_pkg.sv
// Shared types and constants of the stack machine executor.
package sme_pkg;

	localparam int unsigned CMD_W   = 4;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned FAULT_W = 3;

	// Instruction opcodes
	typedef enum logic [CMD_W-1:0] {
		OP_PUSH  = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_MUL   = 4'd3,
		OP_DIV   = 4'd4,
		OP_LOAD  = 4'd5,
		OP_STORE = 4'd6,
		OP_PRINT = 4'd7,
		OP_HALT  = 4'd8
	} op_t;

	// Result kind codes
	typedef enum logic [KIND_W-1:0] {
		KIND_NONE  = 2'd0,
		KIND_PRINT = 2'd1,
		KIND_HALT  = 2'd2
	} kind_t;

	// Fault codes
	typedef enum logic [FAULT_W-1:0] {
		F_OK    = 3'd0,
		F_UNDER = 3'd1,
		F_OVER  = 3'd2,
		F_DIVZ  = 3'd3,
		F_RANGE = 3'd4
	} fault_t;

	// Controller states
	typedef enum logic [1:0] {
		ST_CLR,
		ST_IDLE,
		ST_EXEC,
		ST_DIVW
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic cap;       // latch instruction beat, issue memory reads
		logic commit;    // write back state and load the result register
		logic div_start; // launch the iterative divider
		logic clr_step;  // clear one frame word
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic div_go;    // divide with two operands and a nonzero divisor
		logic halt;      // latched instruction is halt
		logic div_done;  // divider holds a finished quotient
		logic clr_last;  // clearing pass is at the last frame word
	} status_t;

endpackage

FILE: sv/sme_instr_if.sv
// Instruction channel: one beat carries one instruction.
interface sme_instr_if;
	logic                            valid;
	logic                            ready;
	logic [sme_pkg::CMD_W-1:0]       cmd;
	logic [sme_pkg::DATA_W-1:0]      operand;

	modport source (output valid, output cmd, output operand, input ready);
	modport sink (input valid, input cmd, input operand, output ready);
endinterface

FILE: sv/sme_result_if.sv
// Result channel: one beat carries the result of one instruction.
interface sme_result_if;
	logic                            valid;
	logic                            ready;
	logic [sme_pkg::KIND_W-1:0]      out_kind;
	logic [sme_pkg::DATA_W-1:0]      out_value;
	logic [sme_pkg::FAULT_W-1:0]     fault;

	modport source (output valid, output out_kind, output out_value, output fault,
		input ready);
	modport sink (input valid, input out_kind, input out_value, input fault,
		output ready);
endinterface

FILE: sv/sme_div.sv
// Radix-2 restoring divider, one quotient bit per cycle.
module sme_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [sme_pkg::DATA_W-1:0]  dividend,
	input  logic [sme_pkg::DATA_W-1:0]  divisor,
	output logic [sme_pkg::DATA_W-1:0]  quotient,
	output logic                        done
);
	localparam int unsigned W   = sme_pkg::DATA_W;
	localparam int unsigned CNW = $clog2(W);

	logic [W-1:0]   quo_q;
	logic [W-1:0]   rem_q;
	logic [W-1:0]   dvs_q;
	logic [CNW-1:0] cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [W:0]     shifted;
	logic [W:0]     diff;

	// Trial subtract of the divisor from the shifted remainder
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	// Control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNW'(1);
			if (cnt_q == CNW'(W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_q && busy_q))
		else $error("divider done while still iterating");
endmodule

FILE: sv/sme_datapath.sv
// Datapath: operand stack, frame memory, ALU, divider and result register.
module sme_datapath #(
	parameter int unsigned STACK_DEPTH = 16,
	parameter int unsigned FRAME_WORDS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sme_pkg::ctl_t                ctl,
	output sme_pkg::status_t             status,
	input  logic [sme_pkg::CMD_W-1:0]    instr_cmd,
	input  logic [sme_pkg::DATA_W-1:0]   instr_operand,
	output logic [sme_pkg::KIND_W-1:0]   out_kind,
	output logic [sme_pkg::DATA_W-1:0]   out_value,
	output logic [sme_pkg::FAULT_W-1:0]  fault
);
	localparam int unsigned W    = sme_pkg::DATA_W;
	localparam int unsigned SA_W = $clog2(STACK_DEPTH);
	localparam int unsigned CW   = $clog2(STACK_DEPTH + 1);
	localparam int unsigned FA_W = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
	localparam int unsigned XW   = W - 2;

	// Memories
	logic [W-1:0] stk_mem [STACK_DEPTH];
	logic [W-1:0] frm_mem [FRAME_WORDS];

	// Latched instruction and registered read data
	logic [sme_pkg::CMD_W-1:0] cmd_q;
	logic [W-1:0]              opnd_q;
	logic [W-1:0]              top_q;
	logic [W-1:0]              nxt_q;
	logic [W-1:0]              frm_q;
	logic [CW-1:0]             count_q;
	logic [FA_W-1:0]           clr_q;

	logic [sme_pkg::KIND_W-1:0]  kind_q;
	logic [W-1:0]                value_q;
	logic [sme_pkg::FAULT_W-1:0] fault_q;

	logic [CW-1:0]   cnt_m1_in;
	logic [CW-1:0]   cnt_m2_in;
	logic [CW-1:0]   cnt_m1;
	logic [CW-1:0]   cnt_m2;
	logic [FA_W-1:0] fra_in;
	logic [FA_W-1:0] fwa;
	logic            full;
	logic            has1;
	logic            has2;
	logic            range_bad;
	logic            div_go;
	logic [W-1:0]    quo;
	logic            div_done;

	sme_pkg::kind_t  kind_d;
	sme_pkg::fault_t fault_d;
	logic [W-1:0]    value_d;
	logic [CW-1:0]   count_d;
	logic            stk_we;
	logic [SA_W-1:0] stk_wa;
	logic [W-1:0]    stk_wd;
	logic            frm_we;
	logic [W-1:0]    alu_r;

	// Read addresses for the capture cycle
	assign cnt_m1_in = count_q - CW'(1);
	assign cnt_m2_in = count_q - CW'(2);
	assign fra_in    = instr_operand[2 +: FA_W];

	// Stack flags and frame range check on the latched instruction
	assign cnt_m1    = count_q - CW'(1);
	assign cnt_m2    = count_q - CW'(2);
	assign full      = (count_q == CW'(STACK_DEPTH));
	assign has1      = (count_q != '0);
	assign has2      = (count_q >= CW'(2));
	assign range_bad = (opnd_q[W-1:2] >= XW'(FRAME_WORDS));
	assign fwa       = opnd_q[2 +: FA_W];
	assign div_go    = (sme_pkg::op_t'(cmd_q) == sme_pkg::OP_DIV) && has2 &&
		(nxt_q != '0);

	// Divider: top of stack over next entry
	sme_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctl.div_start),
		.dividend (top_q),
		.divisor  (nxt_q),
		.quotient (quo),
		.done     (div_done)
	);

	// Arithmetic on the two top entries
	always_comb begin
		case (sme_pkg::op_t'(cmd_q))
			sme_pkg::OP_ADD: alu_r = top_q + nxt_q;
			sme_pkg::OP_SUB: alu_r = top_q - nxt_q;
			sme_pkg::OP_MUL: alu_r = top_q * nxt_q;
			default:         alu_r = div_go ? quo : '0;
		endcase
	end

	// Decode the latched instruction into state updates and result
	always_comb begin
		kind_d  = sme_pkg::KIND_NONE;
		fault_d = sme_pkg::F_OK;
		value_d = '0;
		count_d = count_q;
		stk_we  = 1'b0;
		stk_wa  = count_q[SA_W-1:0];
		stk_wd  = opnd_q;
		frm_we  = 1'b0;
		unique case (sme_pkg::op_t'(cmd_q))
			sme_pkg::OP_PUSH: begin
				if (full) begin
					fault_d = sme_pkg::F_OVER;
				end else begin
					stk_we  = 1'b1;
					count_d = count_q + CW'(1);
				end
			end
			sme_pkg::OP_ADD, sme_pkg::OP_SUB, sme_pkg::OP_MUL, sme_pkg::OP_DIV: begin
				if (!has2) begin
					fault_d = sme_pkg::F_UNDER;
				end else begin
					if ((sme_pkg::op_t'(cmd_q) == sme_pkg::OP_DIV) && !div_go) begin
						fault_d = sme_pkg::F_DIVZ;
					end
					stk_we  = 1'b1;
					stk_wa  = cnt_m2[SA_W-1:0];
					stk_wd  = alu_r;
					count_d = cnt_m1;
				end
			end
			sme_pkg::OP_LOAD: begin
				if (range_bad) begin
					fault_d = sme_pkg::F_RANGE;
				end else if (full) begin
					fault_d = sme_pkg::F_OVER;
				end else begin
					stk_we  = 1'b1;
					stk_wd  = frm_q;
					count_d = count_q + CW'(1);
				end
			end
			sme_pkg::OP_STORE: begin
				if (range_bad) begin
					fault_d = sme_pkg::F_RANGE;
				end else if (!has1) begin
					fault_d = sme_pkg::F_UNDER;
				end else begin
					frm_we  = 1'b1;
					count_d = cnt_m1;
				end
			end
			sme_pkg::OP_PRINT: begin
				if (!has1) begin
					fault_d = sme_pkg::F_UNDER;
				end else begin
					kind_d  = sme_pkg::KIND_PRINT;
					value_d = top_q;
					count_d = cnt_m1;
				end
			end
			sme_pkg::OP_HALT: begin
				kind_d  = sme_pkg::KIND_HALT;
				count_d = '0;
			end
			default: begin
			end
		endcase
	end

	// Capture the instruction beat
	always_ff @(posedge clk) begin
		if (ctl.cap) begin
			cmd_q  <= instr_cmd;
			opnd_q <= instr_operand;
		end
	end

	// Stack memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (ctl.commit && stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (ctl.cap) begin
			top_q <= stk_mem[cnt_m1_in[SA_W-1:0]];
			nxt_q <= stk_mem[cnt_m2_in[SA_W-1:0]];
		end
	end

	// Frame memory: clearing pass or store, registered read
	always_ff @(posedge clk) begin
		if (ctl.clr_step) begin
			frm_mem[clr_q] <= '0;
		end else if (ctl.commit && frm_we) begin
			frm_mem[fwa] <= top_q;
		end
		if (ctl.cap) begin
			frm_q <= frm_mem[fra_in];
		end
	end

	// Stack count and clearing pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (ctl.commit) begin
				count_q <= count_d;
			end
			if (ctl.clr_step) begin
				clr_q <= status.clr_last ? '0 : clr_q + FA_W'(1);
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			kind_q  <= kind_d;
			value_q <= value_d;
			fault_q <= fault_d;
		end
	end

	assign status.div_go   = div_go;
	assign status.halt     = (sme_pkg::op_t'(cmd_q) == sme_pkg::OP_HALT);
	assign status.div_done = div_done;
	assign status.clr_last = (clr_q == FA_W'(FRAME_WORDS - 1));

	assign out_kind  = kind_q;
	assign out_value = value_q;
	assign fault     = fault_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_halt_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.commit && status.halt) |=> (count_q == '0))
		else $error("halt left entries on the stack");

	a_one_mem_write: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> !(stk_we && frm_we))
		else $error("stack and frame written by one instruction");
endmodule

FILE: sv/sme_ctrl.sv
// Controller: sequences capture, execute, divide wait and frame clearing.
module sme_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              instr_valid,
	output logic              instr_ready,
	output logic              result_valid,
	input  logic              result_ready,
	output sme_pkg::ctl_t     ctl,
	input  sme_pkg::status_t  status
);
	sme_pkg::state_t state_q;
	sme_pkg::state_t state_d;
	logic            out_valid_q;
	logic            out_free;

	// Result slot frees when empty or drained this cycle
	assign out_free = !out_valid_q || result_ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sme_pkg::ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		instr_ready   = 1'b0;
		ctl.cap       = 1'b0;
		ctl.commit    = 1'b0;
		ctl.div_start = 1'b0;
		ctl.clr_step  = 1'b0;
		unique case (state_q)
			sme_pkg::ST_CLR: begin
				ctl.clr_step = 1'b1;
				if (status.clr_last) begin
					state_d = sme_pkg::ST_IDLE;
				end
			end
			sme_pkg::ST_IDLE: begin
				instr_ready = 1'b1;
				if (instr_valid) begin
					ctl.cap = 1'b1;
					state_d = sme_pkg::ST_EXEC;
				end
			end
			sme_pkg::ST_EXEC: begin
				if (status.div_go) begin
					ctl.div_start = 1'b1;
					state_d       = sme_pkg::ST_DIVW;
				end else if (out_free) begin
					ctl.commit = 1'b1;
					state_d    = status.halt ? sme_pkg::ST_CLR : sme_pkg::ST_IDLE;
				end
			end
			sme_pkg::ST_DIVW: begin
				if (status.div_done && out_free) begin
					ctl.commit = 1'b1;
					state_d    = sme_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sme_pkg::ST_IDLE;
			end
		endcase
	end

	// Result valid: set on commit, drop when the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.commit) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.commit |-> (!out_valid_q || result_ready))
		else $error("result overwritten before it was taken");
endmodule

FILE: sv/stack_machine_executor.sv
// Stack machine executor: runs one instruction per beat and returns one result per instruction.
// Each instruction is handled in a capture step, which latches it and reads the two top stack
// entries and the addressed frame word from their memories, then an execute step, which
// executes and writes back. div with a nonzero divisor runs a radix-2 divider for one
// quotient bit a cycle. After reset, and after every halt, the frame memory is zeroed
// one word a cycle while no instruction is taken. A finished result waits in the output
// register; the next instruction is taken meanwhile and stalls in execute or in the divide
// wait only if that register is still full. The top of stack is the left operand.
module stack_machine_executor #(
	parameter int unsigned STACK_DEPTH = 16,
	parameter int unsigned FRAME_WORDS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	sme_instr_if.sink    instr,
	sme_result_if.source result
);
	sme_pkg::ctl_t    ctl;
	sme_pkg::status_t status;

	sme_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.instr_valid  (instr.valid),
		.instr_ready  (instr.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.ctl          (ctl),
		.status       (status)
	);

	sme_datapath #(
		.STACK_DEPTH (STACK_DEPTH),
		.FRAME_WORDS (FRAME_WORDS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.status        (status),
		.instr_cmd     (instr.cmd),
		.instr_operand (instr.operand),
		.out_kind      (result.out_kind),
		.out_value     (result.out_value),
		.fault         (result.fault)
	);
endmodule
